/* design/skrf_pkg.sv */
// Shared types, constants and helpers for the scalar Kalman rate fuser.
// Holds the sequencer control-word format and its microprogram ROM.
// No dependencies.
package skrf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int RATE_W        = 32;
    localparam int VAR_W         = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int DEN_W         = VAR_W + 1;
    localparam int PROD_W        = 2 * VAR_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int DIV_ITERS     = RATE_W;
    localparam int CNT_W         = $clog2(DIV_ITERS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ODOM_OFFSET = 2'd0,
        CFG_MOTION_VAR  = 2'd1,
        CFG_MEAS_VAR    = 2'd2,
        CFG_INIT_VAR    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_IMU  = 1'b0,
        REQ_ODOM = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        OP_FETCH,
        OP_DISPATCH,
        OP_PREDICT,
        OP_MUL_MEAN,
        OP_MUL_IMU,
        OP_MUL_VAR,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    // What holds the step counter in place.
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_ITEM,
        WAIT_OUT
    } wait_t;

    // Jump condition; when false the sequencer falls through to the next step.
    typedef enum logic [1:0] {
        COND_NONE,
        COND_SKIP,
        COND_ITER_LEFT,
        COND_ALWAYS
    } cond_t;

    localparam int UCODE_LEN = 9;
    localparam int STEP_W    = $clog2(UCODE_LEN);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH = step_t'(0);
    localparam step_t STEP_DIV   = step_t'(7);

    typedef struct packed {
        op_t   op;
        wait_t hold;
        cond_t cond;
        step_t target;
    } ucode_t;

    localparam ucode_t UCODE [UCODE_LEN] = '{
        '{OP_FETCH,    WAIT_ITEM, COND_NONE,      STEP_FETCH},
        '{OP_DISPATCH, WAIT_NONE, COND_SKIP,      STEP_FETCH},
        '{OP_PREDICT,  WAIT_NONE, COND_NONE,      STEP_FETCH},
        '{OP_MUL_MEAN, WAIT_NONE, COND_NONE,      STEP_FETCH},
        '{OP_MUL_IMU,  WAIT_NONE, COND_NONE,      STEP_FETCH},
        '{OP_MUL_VAR,  WAIT_NONE, COND_NONE,      STEP_FETCH},
        '{OP_DIV_INIT, WAIT_NONE, COND_NONE,      STEP_FETCH},
        '{OP_DIV_STEP, WAIT_NONE, COND_ITER_LEFT, STEP_DIV},
        '{OP_EMIT,     WAIT_OUT,  COND_ALWAYS,    STEP_FETCH}
    };

    function automatic logic [VAR_W-1:0] motion_var_default(input int frac);
        logic [63:0] v;
        v = 64'd4 << frac;
        return v[VAR_W-1:0];
    endfunction

    function automatic logic [VAR_W-1:0] meas_var_default(input int frac);
        logic [63:0] v;
        v = 64'd1 << (frac - 1);
        return v[VAR_W-1:0];
    endfunction

    function automatic logic [VAR_W-1:0] init_var_default(input int frac);
        logic [63:0] v;
        v = 64'd2000 << frac;
        return (v > 64'hFFFF_FFFF) ? '1 : v[VAR_W-1:0];
    endfunction

    function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [RATE_W+1:0] x);
        if (x > 34'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (x < -34'sd2147483648)
            return 32'sh8000_0000;
        else
            return signed'(x[RATE_W-1:0]);
    endfunction

    function automatic logic [RATE_W-1:0] mag(input logic signed [RATE_W-1:0] x);
        logic signed [RATE_W-1:0] n;
        n = -x;
        return x[RATE_W-1] ? unsigned'(n) : unsigned'(x);
    endfunction

endpackage

/* design/skrf_in_if.sv */
// Input channel of the rate fuser: valid/ready plus one sample beat.
// Depends on skrf_pkg for field widths.
interface skrf_in_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [skrf_pkg::RATE_W-1:0]  sample_value;

    modport source (output valid, output req_type, output sample_value, input ready);
    modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface

/* design/skrf_out_if.sv */
// Result channel of the rate fuser: valid/ready plus one result beat.
// Depends on skrf_pkg for field widths.
interface skrf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [skrf_pkg::RATE_W-1:0]  filtered_rate;
    logic signed [skrf_pkg::RATE_W-1:0]  offset_rate;

    modport source (output valid, output filtered_rate, output offset_rate, input ready);
    modport sink   (input valid, input filtered_rate, input offset_rate, output ready);
endinterface

/* design/scalar_kalman_rate_fuser_unit.sv */
// Odometry item after the first: accepted at step 0, then predicted, weighted and run
// through the 32-step shared-denominator divider; no new item is taken until it is emitted.
// IMU items and the seeding odometry item give no result and return to step 0 after dispatch.
// The result register frees the input side while a result beat waits.
// rst_n clears the sequencer, flags and estimate state asynchronously and loads the
// register defaults; no clearing pass. Uses skrf_pkg, skrf_in_if, skrf_out_if.
module scalar_kalman_rate_fuser_unit #(
    parameter int FRAC_BITS = skrf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [skrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [skrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    skrf_in_if.sink                           sample,
    skrf_out_if.source                        result
);
    import skrf_pkg::*;

    localparam logic [VAR_W-1:0] MOTION_VAR_RST = motion_var_default(FRAC_BITS);
    localparam logic [VAR_W-1:0] MEAS_VAR_RST   = meas_var_default(FRAC_BITS);
    localparam logic [VAR_W-1:0] INIT_VAR_RST   = init_var_default(FRAC_BITS);

    // configuration
    logic signed [RATE_W-1:0] odom_offset_reg;
    logic [VAR_W-1:0]         motion_var_reg;
    logic [VAR_W-1:0]         meas_var_reg;

    // sequencer
    step_t                    step_reg, step_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    ucode_t                   uc;
    logic                     in_fire;
    logic                     out_free;
    logic                     stall;
    logic                     jump;

    // filter state
    logic signed [RATE_W-1:0] mean_reg, mean_next;
    logic [VAR_W-1:0]         var_reg, var_next;
    logic signed [RATE_W-1:0] last_reg, last_next;
    logic signed [RATE_W-1:0] imu_reg, imu_next;
    logic                     first_reg, first_next;

    // working registers
    req_t                     req_reg, req_next;
    logic signed [RATE_W-1:0] sample_reg, sample_next;
    logic signed [RATE_W-1:0] off_reg, off_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic                     acc_neg_reg, acc_neg_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [DEN_W-1:0]         rem_a_reg, rem_a_next;
    logic [RATE_W-1:0]        num_a_reg, num_a_next;
    logic                     big_reg, big_next;
    logic [DEN_W-1:0]         rem_b_reg, rem_b_next;
    logic [VAR_W-1:0]         num_b_reg, num_b_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic signed [RATE_W-1:0] out_filt_reg, out_filt_next;
    logic signed [RATE_W-1:0] out_off_reg, out_off_next;

    // datapath helpers
    logic [VAR_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [VAR_W:0]           var_sum;
    logic [DEN_W:0]           trial_a, trial_b;
    logic signed [RATE_W-1:0] fused;

    assign uc       = UCODE[step_reg];
    assign in_fire  = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign sample.ready         = (uc.op == OP_FETCH);
    assign result.valid         = out_valid_reg;
    assign result.filtered_rate = out_filt_reg;
    assign result.offset_rate   = out_off_reg;

    // next step
    always_comb
    begin
        unique case (uc.hold)
            WAIT_NONE: stall = 1'b0;
            WAIT_ITEM: stall = !in_fire;
            WAIT_OUT:  stall = !out_free;
            default:   stall = 1'b0;
        endcase
        unique case (uc.cond)
            COND_NONE:      jump = 1'b0;
            COND_SKIP:      jump = (req_reg == REQ_IMU) || first_reg;
            COND_ITER_LEFT: jump = (cnt_reg != CNT_W'(DIV_ITERS - 1));
            COND_ALWAYS:    jump = 1'b1;
            default:        jump = 1'b0;
        endcase
        if (stall)
            step_next = step_reg;
        else if (jump)
            step_next = uc.target;
        else
            step_next = step_reg + step_t'(1);
    end

    // shared multiplier
    always_comb
    begin
        unique case (uc.op)
            OP_MUL_MEAN:
            begin
                mul_a = meas_var_reg;
                mul_b = mag(mean_reg);
            end
            OP_MUL_IMU:
            begin
                mul_a = var_reg;
                mul_b = mag(imu_reg);
            end
            default:
            begin
                mul_a = meas_var_reg;
                mul_b = var_reg;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign var_sum = {1'b0, var_reg} + {1'b0, motion_var_reg};
    assign trial_a = {rem_a_reg, num_a_reg[RATE_W-1]} - {1'b0, den_reg};
    assign trial_b = {rem_b_reg, num_b_reg[VAR_W-1]} - {1'b0, den_reg};

    // quotient to saturated signed mean
    always_comb
    begin
        if (den_reg == '0)
            fused = mean_reg;
        else if (acc_neg_reg)
            fused = (big_reg || num_a_reg > 32'h8000_0000) ? 32'sh8000_0000
                                                            : -signed'(num_a_reg);
        else
            fused = (big_reg || num_a_reg[RATE_W-1]) ? 32'sh7FFF_FFFF
                                                      : signed'(num_a_reg);
    end

    // datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        last_next      = last_reg;
        imu_next       = imu_reg;
        first_next     = first_reg;
        req_next       = req_reg;
        sample_next    = sample_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        acc_neg_next   = acc_neg_reg;
        den_next       = den_reg;
        rem_a_next     = rem_a_reg;
        num_a_next     = num_a_reg;
        big_next       = big_reg;
        rem_b_next     = rem_b_reg;
        num_b_next     = num_b_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_filt_next  = out_filt_reg;
        out_off_next   = out_off_reg;

        unique case (uc.op)
            OP_FETCH:
            begin
                if (in_fire)
                begin
                    req_next    = req_t'(sample.req_type);
                    sample_next = sample.sample_value;
                    off_next    = sat_rate((RATE_W+2)'(sample.sample_value)
                                           + (RATE_W+2)'(odom_offset_reg));
                end
            end
            OP_DISPATCH:
            begin
                if (req_reg == REQ_IMU)
                    imu_next = sample_reg;
                else if (first_reg)
                begin
                    // seed the estimate from the first odometry beat
                    mean_next  = off_reg;
                    last_next  = off_reg;
                    first_next = 1'b0;
                end
            end
            OP_PREDICT:
            begin
                mean_next = sat_rate((RATE_W+2)'(mean_reg) + (RATE_W+2)'(off_reg)
                                     - (RATE_W+2)'(last_reg));
                var_next  = var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];
                last_next = off_reg;
            end
            OP_MUL_MEAN:
            begin
                prod_next = mul_p;
                den_next  = {1'b0, meas_var_reg} + {1'b0, var_reg};
            end
            OP_MUL_IMU:
            begin
                acc_next     = {1'b0, prod_reg};
                acc_neg_next = mean_reg[RATE_W-1];
                prod_next    = mul_p;
            end
            OP_MUL_VAR:
            begin
                // signed-magnitude sum of the two weighted terms
                if (acc_neg_reg == imu_reg[RATE_W-1])
                    acc_next = acc_reg + {1'b0, prod_reg};
                else if (acc_reg[PROD_W-1:0] >= prod_reg)
                    acc_next = acc_reg - {1'b0, prod_reg};
                else
                begin
                    acc_next     = {1'b0, prod_reg} - acc_reg;
                    acc_neg_next = imu_reg[RATE_W-1];
                end
                prod_next = mul_p;
            end
            OP_DIV_INIT:
            begin
                big_next   = (acc_reg[ACC_W-1:RATE_W] >= den_reg);
                rem_a_next = acc_reg[ACC_W-1:RATE_W];
                num_a_next = acc_reg[RATE_W-1:0];
                rem_b_next = {1'b0, prod_reg[PROD_W-1:VAR_W]};
                num_b_next = prod_reg[VAR_W-1:0];
                cnt_next   = '0;
            end
            OP_DIV_STEP:
            begin
                // one restoring step per lane; quotient bits shift into num
                if (!trial_a[DEN_W])
                begin
                    rem_a_next = trial_a[DEN_W-1:0];
                    num_a_next = {num_a_reg[RATE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_a_next = {rem_a_reg[DEN_W-2:0], num_a_reg[RATE_W-1]};
                    num_a_next = {num_a_reg[RATE_W-2:0], 1'b0};
                end
                if (!trial_b[DEN_W])
                begin
                    rem_b_next = trial_b[DEN_W-1:0];
                    num_b_next = {num_b_reg[VAR_W-2:0], 1'b1};
                end
                else
                begin
                    rem_b_next = {rem_b_reg[DEN_W-2:0], num_b_reg[VAR_W-1]};
                    num_b_next = {num_b_reg[VAR_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    mean_next      = fused;
                    var_next       = (den_reg == '0) ? '0 : num_b_reg;
                    out_valid_next = 1'b1;
                    out_filt_next  = fused;
                    out_off_next   = off_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odom_offset_reg <= '0;
            motion_var_reg  <= MOTION_VAR_RST;
            meas_var_reg    <= MEAS_VAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ODOM_OFFSET: odom_offset_reg <= signed'(cfg_wdata);
                CFG_MOTION_VAR:  motion_var_reg  <= cfg_wdata;
                CFG_MEAS_VAR:    meas_var_reg    <= cfg_wdata;
                // the initial variance only seeds the estimate at reset
                CFG_INIT_VAR:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FETCH;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            var_reg       <= INIT_VAR_RST;
            last_reg      <= '0;
            imu_reg       <= '0;
            first_reg     <= 1'b1;
            req_reg       <= REQ_IMU;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            mean_reg      <= mean_next;
            var_reg       <= var_next;
            last_reg      <= last_next;
            imu_reg       <= imu_next;
            first_reg     <= first_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        off_reg      <= off_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        acc_neg_reg  <= acc_neg_next;
        den_reg      <= den_next;
        rem_a_reg    <= rem_a_next;
        num_a_reg    <= num_a_next;
        big_reg      <= big_next;
        rem_b_reg    <= rem_b_next;
        num_b_reg    <= num_b_next;
        out_filt_reg <= out_filt_next;
        out_off_reg  <= out_off_next;
    end

endmodule

/* design/skrf_checker.sv */
// Port-level checks for the scalar Kalman rate fuser, attached by bind.
// Depends on scalar_kalman_rate_fuser_unit and skrf_pkg.
module skrf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [skrf_pkg::RATE_W-1:0]       filtered_rate,
    input logic [skrf_pkg::RATE_W-1:0]       offset_rate
);

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(filtered_rate) && $stable(offset_rate))
        else $error("result payload changed while stalled");

    // one item at a time: input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("input still open after accepting a beat");

    // a result is produced only from the final step, never while fetching
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(sample_ready))
        else $error("result appeared while the sequencer was idle");

endmodule

bind scalar_kalman_rate_fuser_unit skrf_checker u_skrf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_valid  (sample.valid),
    .sample_ready  (sample.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .filtered_rate (result.filtered_rate),
    .offset_rate   (result.offset_rate)
);
